### rtl/ajpb_pkg.sv
// Shared types, register codes and constants of the adaptive jitter playout buffer.
package ajpb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FILL_OUT_W = 13;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned WIN_W = 10;
  localparam int unsigned STABLE_W = 12;
  localparam int unsigned AMP_W = 15;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned THR_W = DEPTH_W + FRAME_W;

  localparam logic [FRAME_W-1:0]    FRAME_SIZE_RST     = 8'd160;
  localparam logic [DEPTH_W-1:0]    DEPTH_MIN_RST      = 4'd1;
  localparam logic [DEPTH_W-1:0]    DEPTH_MAX_RST      = 4'd4;
  localparam logic [WIN_W-1:0]      ADAPT_WINDOW_RST   = 10'd50;
  localparam logic [WIN_W-1:0]      UNDERRUN_LIMIT_RST = 10'd3;
  localparam logic [STABLE_W-1:0]   STABLE_WINDOW_RST  = 12'd500;
  localparam logic [AMP_W-1:0]      NOISE_AMP_RST      = 15'd33;
  localparam logic [CFG_DATA_W-1:0] NOISE_SEED_RST     = 32'h1234_5678;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_SIZE     = 3'd0,
    CFG_DEPTH_MIN      = 3'd1,
    CFG_DEPTH_MAX      = 3'd2,
    CFG_ADAPT_WINDOW   = 3'd3,
    CFG_UNDERRUN_LIMIT = 3'd4,
    CFG_STABLE_WINDOW  = 3'd5,
    CFG_NOISE_AMP      = 3'd6,
    CFG_NOISE_SEED     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_size;
    logic [DEPTH_W-1:0]  depth_min;
    logic [DEPTH_W-1:0]  depth_max;
    logic [WIN_W-1:0]    adapt_window;
    logic [WIN_W-1:0]    underrun_limit;
    logic [STABLE_W-1:0] stable_window;
    logic [AMP_W-1:0]    noise_amp;
  } cfg_t;

  // How the word in flight is to be completed.
  typedef struct packed {
    logic pop;
    logic noise;
    logic dropped;
  } kind_t;

  typedef struct packed {
    logic               ready;
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   drops;
    logic [CNT_W-1:0]   underruns;
  } status_t;

endpackage

### rtl/ajpb_ring.sv
// Sample ring memory: one write port and one registered read port.
module ajpb_ring import ajpb_pkg::*; #(
  parameter int unsigned Depth = RING_DEPTH_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [Depth];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ajpb_noise.sv
// Comfort noise generator: 32-bit LCG state and amplitude scaling.
module ajpb_noise import ajpb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       seed_load_i,
  input  logic [CFG_DATA_W-1:0]      seed_i,
  input  logic                       advance_i,
  input  logic [AMP_W-1:0]           amplitude_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  logic [31:0]                state_q, state_d;
  logic signed [SAMPLE_W-1:0] centered;
  logic signed [31:0]         scaled;

  always_comb begin
    state_d = state_q;
    if (seed_load_i) begin
      state_d = seed_i;
    end else if (advance_i) begin
      state_d = state_q * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NOISE_SEED_RST;
    end else begin
      state_q <= state_d;
    end
  end

  // Upper half minus 32768 is the upper half with its top bit flipped.
  assign centered = {~state_q[31], state_q[30:16]};
  assign scaled   = 32'(centered) * $signed({17'd0, amplitude_i});
  // Arithmetic shift gives the floor of the division by 32768.
  assign sample_o = scaled[30:15];

endmodule

### rtl/ajpb_ctrl.sv
// Ring pointers, fill, ready, frame tracking, adaptive depth rule and counters.
module ajpb_ctrl import ajpb_pkg::*; #(
  parameter int unsigned RingDepth = RING_DEPTH_DEF,
  localparam int unsigned AddrW = $clog2(RingDepth),
  localparam int unsigned FillW = $clog2(RingDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic                frame_last_i,
  input  cfg_t                cfg_i,
  output logic                ring_we_o,
  output logic [AddrW-1:0]    ring_waddr_o,
  output logic                ring_re_o,
  output logic [AddrW-1:0]    ring_raddr_o,
  output logic                noise_adv_o,
  output kind_t               kind_o,
  output status_t             status_o,
  output logic [FillW-1:0]    fill_o
);

  localparam int unsigned CmpW = (FillW > THR_W) ? FillW : THR_W;

  logic [AddrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                ready_q, ready_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [WIN_W-1:0]    wf_q, wf_d, wu_q, wu_d;
  logic [STABLE_W-1:0] sf_q, sf_d;
  logic                in_frame_q, in_frame_d, fwr_q, fwr_d, short_q, short_d;
  logic [CNT_W-1:0]    drops_q, drops_d, under_q, under_d;
  kind_t               kind_q, kind_d;

  logic             fwr, short_v, pop, full;
  logic [THR_W-1:0] thr;

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    ready_d     = ready_q;
    depth_d     = depth_q;
    wf_d        = wf_q;
    wu_d        = wu_q;
    sf_d        = sf_q;
    in_frame_d  = in_frame_q;
    fwr_d       = fwr_q;
    short_d     = short_q;
    drops_d     = drops_q;
    under_d     = under_q;
    kind_d      = kind_q;
    ring_we_o   = 1'b0;
    ring_re_o   = 1'b0;
    noise_adv_o = 1'b0;

    // A read that opens a frame samples the ready flag for the whole frame.
    fwr     = in_frame_q ? fwr_q : ready_q;
    short_v = in_frame_q & short_q;
    pop     = fwr && (fill_q != '0);
    full    = (fill_q == FillW'(RingDepth));
    thr     = {{FRAME_W{1'b0}}, depth_q} * {{DEPTH_W{1'b0}}, cfg_i.frame_size};

    if (accept_i) begin
      kind_d = '0;
      case (mode_e'(mode_i))
        MODE_WRITE: begin
          if (full) begin
            kind_d.dropped = 1'b1;
            if (drops_q != '1) begin
              drops_d = drops_q + 1'b1;
            end
          end else begin
            ring_we_o = 1'b1;
            wr_ptr_d  = (wr_ptr_q == AddrW'(RingDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
            fill_d    = fill_q + 1'b1;
          end
          if (!ready_q && (CmpW'(fill_d) >= CmpW'(thr))) begin
            ready_d = 1'b1;
          end
        end
        MODE_READ: begin
          if (pop) begin
            ring_re_o  = 1'b1;
            rd_ptr_d   = (rd_ptr_q == AddrW'(RingDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
            fill_d     = fill_q - 1'b1;
            kind_d.pop = 1'b1;
          end else begin
            kind_d.noise = 1'b1;
            noise_adv_o  = 1'b1;
            short_v      = short_v | fwr;
          end
          if (frame_last_i) begin
            if (fwr) begin
              if (short_v && (under_q != '1)) begin
                under_d = under_q + 1'b1;
              end
              wf_d = wf_q + 1'b1;
              if (short_v) begin
                if (wu_q != '1) begin
                  wu_d = wu_q + 1'b1;
                end
                sf_d = '0;
              end else if (sf_q != '1) begin
                sf_d = sf_q + 1'b1;
              end
              if (wf_d >= cfg_i.adapt_window) begin
                if ((wu_d > cfg_i.underrun_limit) && (depth_q < cfg_i.depth_max)) begin
                  depth_d = depth_q + 1'b1;
                  ready_d = 1'b0;
                end
                wu_d = '0;
                wf_d = '0;
              end
              if ((sf_d >= cfg_i.stable_window) && (depth_d > cfg_i.depth_min)) begin
                depth_d = depth_d - 1'b1;
                sf_d    = '0;
              end
            end
            in_frame_d = 1'b0;
            fwr_d      = 1'b0;
            short_d    = 1'b0;
          end else begin
            in_frame_d = 1'b1;
            fwr_d      = fwr;
            short_d    = short_v;
          end
        end
        MODE_FLUSH: begin
          wr_ptr_d   = '0;
          rd_ptr_d   = '0;
          fill_d     = '0;
          ready_d    = 1'b0;
          in_frame_d = 1'b0;
          fwr_d      = 1'b0;
          short_d    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      ready_q    <= 1'b0;
      depth_q    <= DEPTH_MIN_RST;
      wf_q       <= '0;
      wu_q       <= '0;
      sf_q       <= '0;
      in_frame_q <= 1'b0;
      fwr_q      <= 1'b0;
      short_q    <= 1'b0;
      drops_q    <= '0;
      under_q    <= '0;
      kind_q     <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fill_q     <= fill_d;
      ready_q    <= ready_d;
      depth_q    <= depth_d;
      wf_q       <= wf_d;
      wu_q       <= wu_d;
      sf_q       <= sf_d;
      in_frame_q <= in_frame_d;
      fwr_q      <= fwr_d;
      short_q    <= short_d;
      drops_q    <= drops_d;
      under_q    <= under_d;
      kind_q     <= kind_d;
    end
  end

  assign ring_waddr_o       = wr_ptr_q;
  assign ring_raddr_o       = rd_ptr_q;
  assign kind_o             = kind_q;
  assign fill_o             = fill_q;
  assign status_o.ready     = ready_q;
  assign status_o.depth     = depth_q;
  assign status_o.drops     = drops_q;
  assign status_o.underruns = under_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RingDepth))
    else $error("ring fill count exceeds ring depth");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_re_o |-> (fill_q != '0) && fwr)
    else $error("ring popped while empty or frame not ready");

  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (mode_i == MODE_FLUSH)) |=> (fill_q == '0) && !ready_q && !in_frame_q)
    else $error("flush did not clear the ring state");

endmodule

### rtl/adaptive_jitter_playout_buffer_unit.sv
// At the edge where start is high and busy is low the word is taken in: the ring memory
// is written, its read is launched or the noise generator steps, and the buffer state is
// updated. During the next cycle busy is high while the ring read completes and the
// noise sample is scaled; at its end the result is registered and done_o marks it on
// the result ports for exactly one cycle. busy is low again in that cycle, so a new word
// may start there; no word is taken in while busy is high. Results must be taken when
// done_o is high; the receiver cannot hold them off. Configuration writes take effect
// at once; the user must make them only while no word is in flight, which the block
// does not enforce. There is no memory clearing pass after reset.
module adaptive_jitter_playout_buffer_unit import ajpb_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic                        frame_last_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic                        done_o,
  output logic signed [SAMPLE_W-1:0]  sample_out_o,
  output logic                        is_noise_o,
  output logic                        write_dropped_o,
  output logic                        ready_res_o,
  output logic [DEPTH_W-1:0]          depth_now_o,
  output logic [FILL_OUT_W-1:0]       fill_level_o,
  output logic [CNT_W-1:0]            drop_total_o,
  output logic [CNT_W-1:0]            underrun_total_o
);

  localparam int unsigned AddrW = $clog2(RING_DEPTH);
  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);

  cfg_t                       cfg_q;
  logic                       seed_load;
  logic                       accept;
  logic                       pend_q, done_q;
  logic                       ring_we, ring_re, noise_adv;
  logic [AddrW-1:0]           ring_waddr, ring_raddr;
  logic [SAMPLE_W-1:0]        ring_rdata;
  logic signed [SAMPLE_W-1:0] noise_sample;
  kind_t                      kind;
  status_t                    status;
  logic [FillW-1:0]           fill;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       noise_q, dropped_q, ready_q;
  logic [DEPTH_W-1:0]         depth_q;
  logic [FILL_OUT_W-1:0]      fill_q;
  logic [CNT_W-1:0]           drops_q, under_q;

  assign accept    = start && !pend_q;
  assign busy      = pend_q;
  assign seed_load = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_NOISE_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_size     <= FRAME_SIZE_RST;
      cfg_q.depth_min      <= DEPTH_MIN_RST;
      cfg_q.depth_max      <= DEPTH_MAX_RST;
      cfg_q.adapt_window   <= ADAPT_WINDOW_RST;
      cfg_q.underrun_limit <= UNDERRUN_LIMIT_RST;
      cfg_q.stable_window  <= STABLE_WINDOW_RST;
      cfg_q.noise_amp      <= NOISE_AMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_SIZE:     cfg_q.frame_size     <= cfg_wdata_i[FRAME_W-1:0];
        CFG_DEPTH_MIN:      cfg_q.depth_min      <= cfg_wdata_i[DEPTH_W-1:0];
        CFG_DEPTH_MAX:      cfg_q.depth_max      <= cfg_wdata_i[DEPTH_W-1:0];
        CFG_ADAPT_WINDOW:   cfg_q.adapt_window   <= cfg_wdata_i[WIN_W-1:0];
        CFG_UNDERRUN_LIMIT: cfg_q.underrun_limit <= cfg_wdata_i[WIN_W-1:0];
        CFG_STABLE_WINDOW:  cfg_q.stable_window  <= cfg_wdata_i[STABLE_W-1:0];
        CFG_NOISE_AMP:      cfg_q.noise_amp      <= cfg_wdata_i[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ajpb_ctrl #(
    .RingDepth(RING_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .frame_last_i (frame_last_i),
    .cfg_i        (cfg_q),
    .ring_we_o    (ring_we),
    .ring_waddr_o (ring_waddr),
    .ring_re_o    (ring_re),
    .ring_raddr_o (ring_raddr),
    .noise_adv_o  (noise_adv),
    .kind_o       (kind),
    .status_o     (status),
    .fill_o       (fill)
  );

  ajpb_ring #(
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (sample_in_i),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  ajpb_noise u_noise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (seed_load),
    .seed_i      (cfg_wdata_i),
    .advance_i   (noise_adv),
    .amplitude_i (cfg_q.noise_amp),
    .sample_o    (noise_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= accept;
      done_q <= pend_q;
    end
  end

  // Result word is captured at the end of the cycle in which busy is high.
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      if (kind.pop) begin
        sample_q <= ring_rdata;
      end else if (kind.noise) begin
        sample_q <= noise_sample;
      end else begin
        sample_q <= '0;
      end
      noise_q   <= kind.noise;
      dropped_q <= kind.dropped;
      ready_q   <= status.ready;
      depth_q   <= status.depth;
      fill_q    <= FILL_OUT_W'(fill);
      drops_q   <= status.drops;
      under_q   <= status.underruns;
    end
  end

  assign done_o           = done_q;
  assign sample_out_o     = sample_q;
  assign is_noise_o       = noise_q;
  assign write_dropped_o  = dropped_q;
  assign ready_res_o      = ready_q;
  assign depth_now_o      = depth_q;
  assign fill_level_o     = fill_q;
  assign drop_total_o     = drops_q;
  assign underrun_total_o = under_q;

  a_busy_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy && done_o)
    else $error("item stayed in flight longer than one cycle");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without an item in flight");

  a_kind_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $countones({kind.pop, kind.noise, kind.dropped}) <= 1)
    else $error("result word has more than one source");

endmodule
